FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands; expect clock and reset in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CSC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("csc assertion failed");

// next-cycle implication, disabled during reset
`define CSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("csc assertion failed");

`endif

FILE: src/csc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types and constants for the connection slot classifier.
// ----------------------------------------------------------------------------
package csc_pkg;

   localparam int SLOTS    = 8;
   localparam int SLOT_AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W    = 32;
   localparam int TOTAL_W  = 5;
   localparam logic [4:0] SLOT_LIMIT = 5'(SLOTS);

   typedef enum logic [2:0] {
      MODE_CONNECT    = 3'd0,
      MODE_CLASSIFY   = 3'd1,
      MODE_DISCONNECT = 3'd2,
      MODE_QUERY      = 3'd3,
      MODE_CLEAR      = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      KIND_FREE  = 2'd0,
      KIND_UNCL  = 2'd1,
      KIND_PEER  = 2'd2,
      KIND_PHONE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_ALREADY = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch the request word
      logic execute;   // table update and result load
   } csc_cmd_type;

endpackage

FILE: src/csc_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_req_if / csc_rsp_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface csc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [3:0] slot_index;
   logic [1:0] new_kind;
   logic       classify_reason;

   modport source (output valid, mode, slot_index, new_kind, classify_reason,
                   input ready);
   modport sink   (input valid, mode, slot_index, new_kind, classify_reason,
                   output ready);
endinterface

interface csc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        released_phone_note;
   logic [1:0]  slot_kind;
   logic        slot_phone_noted;
   logic [4:0]  active_count;
   logic [4:0]  unclassified_count;
   logic [31:0] out_of_range_count;
   logic [31:0] peer_by_role_count;
   logic [31:0] peer_by_hello_count;
   logic [31:0] phone_by_timer_count;
   logic [31:0] phone_by_traffic_count;
   logic [31:0] phone_unnote_count;

   modport source (output valid, status, released_phone_note, slot_kind,
                   slot_phone_noted, active_count, unclassified_count,
                   out_of_range_count, peer_by_role_count, peer_by_hello_count,
                   phone_by_timer_count, phone_by_traffic_count,
                   phone_unnote_count,
                   input ready);
   modport sink   (input valid, status, released_phone_note, slot_kind,
                   slot_phone_noted, active_count, unclassified_count,
                   out_of_range_count, peer_by_role_count, peer_by_hello_count,
                   phone_by_timer_count, phone_by_traffic_count,
                   phone_unnote_count,
                   output ready);
endinterface

FILE: src/connection_slot_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_slot_classifier_core
// Connection slot table with classify/disconnect logic and event counters.
// ----------------------------------------------------------------------------
// Each request word is first latched; then the read-modify-write of the slot
// table, totals and counters runs, which also loads the response register.
// The update waits while a previous response is still held by the consumer,
// and a new word is taken only once the update of the last one has run.
// Clear-all finishes in its own update; no clearing pass is needed after
// reset.
module connection_slot_classifier_core (
   input  logic      clock,
   input  logic      reset,
   csc_req_if.sink   req_bus,
   csc_rsp_if.source rsp_bus
);
   import csc_pkg::*;

   csc_cmd_type cmd;

   csc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   csc_datapath u_dp (
      .clock                      (clock),
      .reset                      (reset),
      .cmd                        (cmd),
      .req_mode                   (req_bus.mode),
      .req_slot_index             (req_bus.slot_index),
      .req_new_kind               (req_bus.new_kind),
      .req_classify_reason        (req_bus.classify_reason),
      .rsp_status                 (rsp_bus.status),
      .rsp_released_phone_note    (rsp_bus.released_phone_note),
      .rsp_slot_kind              (rsp_bus.slot_kind),
      .rsp_slot_phone_noted       (rsp_bus.slot_phone_noted),
      .rsp_active_count           (rsp_bus.active_count),
      .rsp_unclassified_count     (rsp_bus.unclassified_count),
      .rsp_out_of_range_count     (rsp_bus.out_of_range_count),
      .rsp_peer_by_role_count     (rsp_bus.peer_by_role_count),
      .rsp_peer_by_hello_count    (rsp_bus.peer_by_hello_count),
      .rsp_phone_by_timer_count   (rsp_bus.phone_by_timer_count),
      .rsp_phone_by_traffic_count (rsp_bus.phone_by_traffic_count),
      .rsp_phone_unnote_count     (rsp_bus.phone_unnote_count)
   );

endmodule

FILE: src/csc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_datapath
// Slot table, running totals, event counters and the result register.
// ----------------------------------------------------------------------------
module csc_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  csc_pkg::csc_cmd_type    cmd,
   input  logic [2:0]              req_mode,
   input  logic [3:0]              req_slot_index,
   input  logic [1:0]              req_new_kind,
   input  logic                    req_classify_reason,
   output logic [1:0]              rsp_status,
   output logic                    rsp_released_phone_note,
   output logic [1:0]              rsp_slot_kind,
   output logic                    rsp_slot_phone_noted,
   output logic [4:0]              rsp_active_count,
   output logic [4:0]              rsp_unclassified_count,
   output logic [31:0]             rsp_out_of_range_count,
   output logic [31:0]             rsp_peer_by_role_count,
   output logic [31:0]             rsp_peer_by_hello_count,
   output logic [31:0]             rsp_phone_by_timer_count,
   output logic [31:0]             rsp_phone_by_traffic_count,
   output logic [31:0]             rsp_phone_unnote_count
);
   import csc_pkg::*;

   // captured request word
   mode_type           mode_ff;
   logic [3:0]         index_ff;
   kind_type           want_ff;
   logic               timer_ff;

   // slot table and totals
   kind_type           kind_ff  [SLOTS];
   kind_type           kind_in  [SLOTS];
   logic [SLOTS-1:0]   noted_ff;
   logic [SLOTS-1:0]   noted_in;
   logic [TOTAL_W-1:0] active_ff, active_in;
   logic [TOTAL_W-1:0] uncl_ff, uncl_in;

   // event counters
   logic [CNT_W-1:0]   range_cnt_ff, range_cnt_in;
   logic [CNT_W-1:0]   role_cnt_ff, role_cnt_in;
   logic [CNT_W-1:0]   hello_cnt_ff, hello_cnt_in;
   logic [CNT_W-1:0]   timer_cnt_ff, timer_cnt_in;
   logic [CNT_W-1:0]   traffic_cnt_ff, traffic_cnt_in;
   logic [CNT_W-1:0]   unnote_cnt_ff, unnote_cnt_in;

   // result register
   status_type         status_ff, status_in;
   logic               released_ff, released_in;
   kind_type           slot_kind_ff;
   logic               slot_noted_ff;

   logic [SLOT_AW-1:0] sel;
   logic               in_range;
   kind_type           kind_rd;
   logic               noted_rd;

   assign sel      = index_ff[SLOT_AW-1:0];
   assign in_range = {1'b0, index_ff} < SLOT_LIMIT;
   assign kind_rd  = kind_ff[sel];
   assign noted_rd = noted_ff[sel];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= mode_type'(req_mode);
         index_ff <= req_slot_index;
         want_ff  <= kind_type'(req_new_kind);
         timer_ff <= req_classify_reason;
      end
   end

   always_comb begin
      kind_in        = kind_ff;
      noted_in       = noted_ff;
      active_in      = active_ff;
      uncl_in        = uncl_ff;
      range_cnt_in   = range_cnt_ff;
      role_cnt_in    = role_cnt_ff;
      hello_cnt_in   = hello_cnt_ff;
      timer_cnt_in   = timer_cnt_ff;
      traffic_cnt_in = traffic_cnt_ff;
      unnote_cnt_in  = unnote_cnt_ff;
      status_in      = ST_OK;
      released_in    = 1'b0;
      case (mode_ff)
         MODE_CONNECT: begin
            if (!in_range) begin
               range_cnt_in = range_cnt_ff + 32'd1;
               status_in    = ST_INVALID;
            end else if (want_ff != KIND_UNCL && want_ff != KIND_PEER) begin
               status_in = ST_INVALID;
            end else if (kind_rd != KIND_FREE) begin
               status_in = ST_ALREADY;
            end else begin
               kind_in[sel]  = want_ff;
               noted_in[sel] = 1'b0;
               active_in     = active_ff + 5'd1;
               if (want_ff == KIND_UNCL) begin
                  uncl_in = uncl_ff + 5'd1;
               end else begin
                  role_cnt_in = role_cnt_ff + 32'd1;
               end
            end
         end
         MODE_CLASSIFY: begin
            if (!in_range) begin
               range_cnt_in = range_cnt_ff + 32'd1;
               status_in    = ST_INVALID;
            end else if (want_ff != KIND_PHONE && want_ff != KIND_PEER) begin
               status_in = ST_INVALID;
            end else if (kind_rd == KIND_FREE) begin
               status_in = ST_INVALID;
            end else if (kind_rd != KIND_UNCL) begin
               status_in = ST_ALREADY;
            end else begin
               kind_in[sel] = want_ff;
               uncl_in      = uncl_ff - 5'd1;
               if (want_ff == KIND_PHONE) begin
                  noted_in[sel] = 1'b1;
                  if (timer_ff) begin
                     timer_cnt_in = timer_cnt_ff + 32'd1;
                  end else begin
                     traffic_cnt_in = traffic_cnt_ff + 32'd1;
                  end
               end else begin
                  hello_cnt_in = hello_cnt_ff + 32'd1;
               end
            end
         end
         MODE_DISCONNECT: begin
            if (!in_range) begin
               range_cnt_in = range_cnt_ff + 32'd1;
               status_in    = ST_INVALID;
            end else if (kind_rd == KIND_FREE) begin
               status_in = ST_INVALID;
            end else begin
               released_in = noted_rd;
               if (kind_rd == KIND_UNCL) begin
                  uncl_in = uncl_ff - 5'd1;
               end
               active_in     = active_ff - 5'd1;
               kind_in[sel]  = KIND_FREE;
               noted_in[sel] = 1'b0;
               if (noted_rd) begin
                  unnote_cnt_in = unnote_cnt_ff + 32'd1;
               end
            end
         end
         MODE_QUERY: begin
            status_in = in_range ? ST_OK : ST_INVALID;
         end
         MODE_CLEAR: begin
            kind_in        = '{default: KIND_FREE};
            noted_in       = '0;
            active_in      = '0;
            uncl_in        = '0;
            range_cnt_in   = '0;
            role_cnt_in    = '0;
            hello_cnt_in   = '0;
            timer_cnt_in   = '0;
            traffic_cnt_in = '0;
            unnote_cnt_in  = '0;
         end
         default: begin
            status_in = ST_INVALID;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            kind_ff[i] <= KIND_FREE;
         end
         noted_ff       <= '0;
         active_ff      <= '0;
         uncl_ff        <= '0;
         range_cnt_ff   <= '0;
         role_cnt_ff    <= '0;
         hello_cnt_ff   <= '0;
         timer_cnt_ff   <= '0;
         traffic_cnt_ff <= '0;
         unnote_cnt_ff  <= '0;
      end else if (cmd.execute) begin
         kind_ff        <= kind_in;
         noted_ff       <= noted_in;
         active_ff      <= active_in;
         uncl_ff        <= uncl_in;
         range_cnt_ff   <= range_cnt_in;
         role_cnt_ff    <= role_cnt_in;
         hello_cnt_ff   <= hello_cnt_in;
         timer_cnt_ff   <= timer_cnt_in;
         traffic_cnt_ff <= traffic_cnt_in;
         unnote_cnt_ff  <= unnote_cnt_in;
      end
   end

   // slot fields show the state after the update
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff     <= status_in;
         released_ff   <= released_in;
         slot_kind_ff  <= in_range ? kind_in[sel] : KIND_FREE;
         slot_noted_ff <= in_range ? noted_in[sel] : 1'b0;
      end
   end

   assign rsp_status                 = status_ff;
   assign rsp_released_phone_note    = released_ff;
   assign rsp_slot_kind              = slot_kind_ff;
   assign rsp_slot_phone_noted       = slot_noted_ff;
   assign rsp_active_count           = active_ff;
   assign rsp_unclassified_count     = uncl_ff;
   assign rsp_out_of_range_count     = range_cnt_ff;
   assign rsp_peer_by_role_count     = role_cnt_ff;
   assign rsp_peer_by_hello_count    = hello_cnt_ff;
   assign rsp_phone_by_timer_count   = timer_cnt_ff;
   assign rsp_phone_by_traffic_count = traffic_cnt_ff;
   assign rsp_phone_unnote_count     = unnote_cnt_ff;

endmodule

FILE: src/csc_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_controller
// Sequencer: takes a request word, runs its update once the result
// register is free, and holds the response valid.
// ----------------------------------------------------------------------------
module csc_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output csc_pkg::csc_cmd_type cmd
);
   import csc_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } ctl_state_type;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   // no word is taken while reset is held
   assign req_ready   = (state_ff == S_IDLE) && !reset;
   assign cmd.capture = req_valid && req_ready;
   assign cmd.execute = (state_ff == S_EXEC) && out_free;
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.capture) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cmd.execute) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: src/csc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_checker
// Port-level checks for the connection slot classifier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [4:0] active_count,
   input logic [4:0] unclassified_count
);
   import csc_pkg::*;

   // a pending response word stays up until taken
   `CSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // one word in flight: no second word right after one is taken
   `CSC_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

   // nothing to report straight out of reset
   `CSC_ASSERT_NOW(a_reset_quiet, $past(reset), !rsp_valid)

   // running totals stay consistent with the table size
   `CSC_ASSERT_NOW(a_totals_bound, rsp_valid,
      active_count <= SLOT_LIMIT && unclassified_count <= active_count)

endmodule

bind connection_slot_classifier_core csc_checker u_csc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .active_count       (rsp_bus.active_count),
   .unclassified_count (rsp_bus.unclassified_count)
);
